[hdl/cpa_pkg.sv]
`timescale 1ns / 1ps

package cpa_pkg;

    localparam int ADDR_W      = 32;
    localparam int BASE_PAGE_W = 20;
    localparam int COUNT_W     = 6;
    localparam int STATUS_W    = 3;

    localparam logic [BASE_PAGE_W-1:0] BASE_PAGE_RESET = 20'd32;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_ALLOCATED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_RUN    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FREED     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd4;

    typedef struct packed {
        logic              req_type;
        logic [ADDR_W-1:0] size_bytes;
        logic [ADDR_W-1:0] alignment_bytes;
        logic [ADDR_W-1:0] free_address;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   run_address;
        logic [COUNT_W-1:0]  run_pages;
    } t_rsp;

endpackage

[hdl/contiguous_page_allocator_unit.sv]
`timescale 1ns / 1ps

// Channel    Direction  Handshake                    Payload
// request    in         i_req_valid / o_req_ready    i_req (t_req)
// response   out        o_rsp_valid / i_rsp_ready    o_rsp (t_rsp)
// config     in         i_cfg_we, no wait            i_cfg_wdata (window base page)
//
// One request is in flight at a time. An allocate scans the page map through the single
// read port, then marks each page of the run in turn, with decode and hand-off around
// them. A free checks the run's head entry, then clears each page of the run in turn.
// After reset, a clearing pass writes every page-map entry, one per cycle, before the
// first request is taken. A finished response waits in the output register while the
// next request is taken.

module contiguous_page_allocator_unit #(
    parameter int NUM_PAGES      = 32,
    parameter int PAGE_SIZE_LOG2 = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [cpa_pkg::BASE_PAGE_W-1:0]     i_cfg_wdata,
    input  logic                                i_req_valid,
    output logic                                o_req_ready,
    input  cpa_pkg::t_req                       i_req,
    output logic                                o_rsp_valid,
    input  logic                                i_rsp_ready,
    output cpa_pkg::t_rsp                       o_rsp
);
    import cpa_pkg::*;

    localparam int IDX_W  = $clog2(NUM_PAGES);
    localparam int CNT_W  = $clog2(NUM_PAGES + 1);
    localparam int BASE_W = BASE_PAGE_W + PAGE_SIZE_LOG2;
    localparam int DIFF_W = ((BASE_W > ADDR_W) ? BASE_W : ADDR_W) + 1;

    localparam logic [ADDR_W:0]   PAGE_BYTES   = (ADDR_W + 1)'(1) << PAGE_SIZE_LOG2;
    localparam logic [ADDR_W:0]   WINDOW_BYTES = (ADDR_W + 1)'(NUM_PAGES) << PAGE_SIZE_LOG2;
    localparam logic [DIFF_W-1:0] WINDOW_DIFF  = DIFF_W'(NUM_PAGES) << PAGE_SIZE_LOG2;
    localparam logic [IDX_W-1:0]  LAST_IDX     = IDX_W'(NUM_PAGES - 1);
    localparam logic [CNT_W-1:0]  PAGE_CNT_C   = CNT_W'(NUM_PAGES);

    typedef struct packed {
        logic               used;
        logic [COUNT_W-1:0] pages;
    } t_entry;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_MARK,
        S_FREE_CHK,
        S_FREE_CLR,
        S_DONE
    } t_state;

    t_entry r_mem [NUM_PAGES];
    t_entry r_rdata;

    t_state                  r_state;
    logic [BASE_PAGE_W-1:0]  r_base_page;
    t_req                    r_req;
    t_rsp                    r_res;
    t_rsp                    r_out;
    logic                    r_out_valid;
    logic [CNT_W-1:0]        r_need;
    logic [CNT_W-1:0]        r_issue;
    logic                    r_pend;
    logic [IDX_W-1:0]        r_pend_idx;
    logic [CNT_W-1:0]        r_run_len;
    logic [IDX_W-1:0]        r_wr_idx;
    logic [IDX_W-1:0]        r_start;
    logic [CNT_W-1:0]        r_wr_cnt;
    logic [COUNT_W-1:0]      r_left;

    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    t_entry            wr_data;

    logic [ADDR_W:0]   size_x;
    logic [ADDR_W:0]   align_x;
    logic [ADDR_W:0]   need_sum;
    logic              alloc_bad;
    logic [CNT_W-1:0]  need;
    logic [BASE_W-1:0] base_bytes;
    logic [DIFF_W-1:0] diff;
    logic              free_ok;
    logic [IDX_W-1:0]  free_idx;
    logic [CNT_W-1:0]  n_run_len;
    logic              hit;
    logic [IDX_W-1:0]  hit_start;
    logic [ADDR_W-1:0] alloc_addr;

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    assign size_x     = {1'b0, r_req.size_bytes};
    assign align_x    = {1'b0, r_req.alignment_bytes};
    assign need_sum   = size_x + PAGE_BYTES - (ADDR_W + 1)'(1);
    assign need       = CNT_W'(need_sum >> PAGE_SIZE_LOG2);
    assign alloc_bad  = (r_req.size_bytes == '0) || (r_req.alignment_bytes == '0)
                     || ((r_req.alignment_bytes & (r_req.alignment_bytes - ADDR_W'(1))) != '0)
                     || (align_x > PAGE_BYTES) || (size_x > WINDOW_BYTES);

    assign base_bytes = {r_base_page, {PAGE_SIZE_LOG2{1'b0}}};
    assign diff       = DIFF_W'(r_req.free_address) - DIFF_W'(base_bytes);
    assign free_ok    = !diff[DIFF_W-1] && (diff < WINDOW_DIFF)
                     && (diff[PAGE_SIZE_LOG2-1:0] == '0);
    assign free_idx   = diff[PAGE_SIZE_LOG2 +: IDX_W];

    assign n_run_len  = r_rdata.used ? '0 : CNT_W'(r_run_len + CNT_W'(1));
    assign hit        = !r_rdata.used && (CNT_W'(r_run_len + CNT_W'(1)) == r_need);
    assign hit_start  = r_pend_idx - IDX_W'(r_need - CNT_W'(1));
    assign alloc_addr = ADDR_W'(base_bytes) + (ADDR_W'(r_start) << PAGE_SIZE_LOG2);

    always_comb begin
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = r_wr_idx;
        wr_data = '0;
        case (r_state)
            S_INIT: begin
                wr_en = 1'b1;
            end
            S_DECODE: begin
                rd_addr = free_idx;
            end
            S_SCAN: begin
                rd_addr = r_issue[IDX_W-1:0];
            end
            S_MARK: begin
                wr_en         = 1'b1;
                wr_data.used  = 1'b1;
                wr_data.pages = (r_wr_cnt == '0) ? COUNT_W'(r_need) : '0;
            end
            S_FREE_CLR: begin
                wr_en = 1'b1;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_base_page <= BASE_PAGE_RESET;
            r_out_valid <= 1'b0;
            r_wr_idx    <= '0;
            r_pend      <= 1'b0;
            r_issue     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_base_page <= i_cfg_wdata;
            end
            if (r_out_valid && i_rsp_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_INIT: begin
                    r_wr_idx <= IDX_W'(r_wr_idx + IDX_W'(1));
                    if (r_wr_idx == LAST_IDX) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_req   <= i_req;
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    if (r_req.req_type == REQ_FREE) begin
                        if (free_ok) begin
                            r_res    <= '0;
                            r_wr_idx <= free_idx;
                            r_state  <= S_FREE_CHK;
                        end else begin
                            r_res   <= '{ST_IGNORED, ADDR_W'(0), COUNT_W'(0)};
                            r_state <= S_DONE;
                        end
                    end else if (alloc_bad) begin
                        r_res   <= '{ST_BAD, ADDR_W'(0), COUNT_W'(0)};
                        r_state <= S_DONE;
                    end else begin
                        r_res     <= '0;
                        r_need    <= need;
                        r_issue   <= '0;
                        r_pend    <= 1'b0;
                        r_run_len <= '0;
                        r_state   <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_pend <= (r_issue != PAGE_CNT_C);
                    if (r_issue != PAGE_CNT_C) begin
                        r_pend_idx <= r_issue[IDX_W-1:0];
                        r_issue    <= CNT_W'(r_issue + CNT_W'(1));
                    end
                    if (r_pend) begin
                        r_run_len <= n_run_len;
                        if (hit) begin
                            r_start  <= hit_start;
                            r_wr_idx <= hit_start;
                            r_wr_cnt <= '0;
                            r_state  <= S_MARK;
                        end else if (r_pend_idx == LAST_IDX) begin
                            r_res.status <= ST_NO_RUN;
                            r_state      <= S_DONE;
                        end
                    end
                end
                S_MARK: begin
                    r_wr_idx <= IDX_W'(r_wr_idx + IDX_W'(1));
                    r_wr_cnt <= CNT_W'(r_wr_cnt + CNT_W'(1));
                    if (r_wr_cnt == CNT_W'(r_need - CNT_W'(1))) begin
                        r_res.status      <= ST_ALLOCATED;
                        r_res.run_address <= alloc_addr;
                        r_res.run_pages   <= COUNT_W'(r_need);
                        r_state           <= S_DONE;
                    end
                end
                S_FREE_CHK: begin
                    if (r_rdata.used && (r_rdata.pages != '0)) begin
                        r_left            <= r_rdata.pages;
                        r_res.status      <= ST_FREED;
                        r_res.run_address <= r_req.free_address;
                        r_res.run_pages   <= r_rdata.pages;
                        r_state           <= S_FREE_CLR;
                    end else begin
                        r_res.status <= ST_IGNORED;
                        r_state      <= S_DONE;
                    end
                end
                S_FREE_CLR: begin
                    r_wr_idx <= IDX_W'(r_wr_idx + IDX_W'(1));
                    r_left   <= COUNT_W'(r_left - COUNT_W'(1));
                    if ((r_left <= COUNT_W'(1)) || (r_wr_idx == LAST_IDX)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_rsp_ready) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
